// File: src/pidaw_pkg.sv
// ============================================================================
// PID controller package
// Shared widths, register indexes, reset values and the saturation helper.
// ============================================================================
package pidaw_pkg;

  // Saturation width and default number of fraction bits.
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Width of every data field on the ports and of the stored state.
  localparam int FIELD_W = 32;
  // Width of the unsigned gain and time registers.
  localparam int GAIN_W  = 31;
  // Multiplier operand and product widths.
  localparam int OPND_W  = FIELD_W + 1;
  localparam int PROD_W  = 2 * OPND_W;
  // Width of the derivative denominator 2*tau + T.
  localparam int DEN_W   = GAIN_W + 2;
  // Width of the register index on the configuration port.
  localparam int ADDR_W  = 3;

  // Effective saturation width: wider settings behave as 32 bits.
  localparam int SAT_W = (DATA_WIDTH > FIELD_W) ? FIELD_W : DATA_WIDTH;
  localparam longint SAT_MAX_L = (longint'(1) <<< (SAT_W - 1)) - 1;
  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(SAT_MAX_L);
  localparam logic signed [PROD_W-1:0] SAT_MIN = PROD_W'(-SAT_MAX_L - 1);

  // Configuration register indexes.
  typedef enum logic [ADDR_W-1:0] {
    REG_KP          = 3'd0,
    REG_KI          = 3'd1,
    REG_KD          = 3'd2,
    REG_SAMPLE_TIME = 3'd3,
    REG_FILTER_TAU  = 3'd4,
    REG_OUT_MIN     = 3'd5,
    REG_OUT_MAX     = 3'd6
  } reg_index_t;

  // Register reset values.
  localparam logic [GAIN_W-1:0] KP_RST          = 31'd65536;
  localparam logic [GAIN_W-1:0] KI_RST          = 31'd65536;
  localparam logic [GAIN_W-1:0] KD_RST          = 31'd0;
  localparam logic [GAIN_W-1:0] SAMPLE_TIME_RST = 31'd655;
  localparam logic [GAIN_W-1:0] FILTER_TAU_RST  = 31'd1311;
  localparam logic signed [FIELD_W-1:0] OUT_MIN_RST = -32'sd65536;
  localparam logic signed [FIELD_W-1:0] OUT_MAX_RST = 32'sd65536;

  // Right shift applied to a product after the multiply.
  typedef enum logic [1:0] {
    SHIFT_FM1,
    SHIFT_F,
    SHIFT_FP1
  } mul_shift_t;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clip a wide signed value to the signed saturation range.
  function automatic logic signed [FIELD_W-1:0] sat_data(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] y;
    if (x > SAT_MAX) begin
      y = SAT_MAX;
    end else if (x < SAT_MIN) begin
      y = SAT_MIN;
    end else begin
      y = x;
    end
    return y[FIELD_W-1:0];
  endfunction

endpackage

// File: src/pidaw_mul.sv
// ============================================================================
// PID shared multiplier
// Registered signed multiply followed by a floor shift and saturation.
// ============================================================================
module pidaw_mul #(
  parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS
) (
  input  logic                                   clk,
  input  logic signed [pidaw_pkg::OPND_W-1:0]    op_a,
  input  logic signed [pidaw_pkg::OPND_W-1:0]    op_b,
  input  pidaw_pkg::mul_shift_t                  shift,
  output logic signed [pidaw_pkg::FIELD_W-1:0]   result
);

  logic signed [pidaw_pkg::PROD_W-1:0] prod;
  logic signed [pidaw_pkg::PROD_W-1:0] shifted;
  pidaw_pkg::mul_shift_t               shift_q;

  always_ff @(posedge clk) begin
    prod    <= op_a * op_b;
    shift_q <= shift;
  end

  // An arithmetic right shift of a two's complement value rounds toward
  // minus infinity, which is the rounding the controller needs.
  always_comb begin
    unique case (shift_q)
      pidaw_pkg::SHIFT_FM1: shifted = prod >>> (FRAC_BITS - 1);
      pidaw_pkg::SHIFT_F:   shifted = prod >>> FRAC_BITS;
      pidaw_pkg::SHIFT_FP1: shifted = prod >>> (FRAC_BITS + 1);
      default:              shifted = prod >>> FRAC_BITS;
    endcase
  end

  assign result = pidaw_pkg::sat_data(shifted);

endmodule

// File: src/pidaw_div.sv
// ============================================================================
// PID derivative divider
// Restoring divider, one quotient bit per cycle, saturated magnitude result.
// ============================================================================
module pidaw_div #(
  parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [pidaw_pkg::FIELD_W-1:0]       dividend,
  input  logic [pidaw_pkg::DEN_W-1:0]         divisor,
  output pidaw_pkg::div_stat_t                stat,
  output logic [pidaw_pkg::FIELD_W-2:0]       quot
);

  localparam int NUM_W = pidaw_pkg::FIELD_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int DEN_W = pidaw_pkg::DEN_W;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [NUM_W-1:0] dvd;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // The dividend register shifts out numerator bits at the top and takes
  // quotient bits in at the bottom, so it ends holding the quotient.
  always_comb begin
    trial = {rem, dvd[NUM_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        rem  <= '0;
        dvs  <= divisor;
        dvd  <= {dividend, {FRAC_BITS{1'b0}}};
      end else if (busy) begin
        rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        dvd <= {dvd[NUM_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  // Quotients beyond the positive range collapse to the largest magnitude.
  assign quot = (dvd[NUM_W-1:pidaw_pkg::FIELD_W-1] != '0) ? '1
                                                         : dvd[pidaw_pkg::FIELD_W-2:0];

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("divider busy with an exhausted bit count");

endmodule

// File: src/pid_controller_antiwindup.sv
// ============================================================================
// PID controller with anti-windup
// Trapezoidal integral, dynamic integrator clamping and filtered derivative.
// ============================================================================
// Each request carries a setpoint and a measurement in signed fixed point with
// FRAC_BITS fraction bits and yields one saturated drive value. The block
// works on one request at a time: five products go one after another through
// a single shared multiplier, and the derivative term is divided by
// 2*tau + T in a restoring divider that produces one quotient bit per clock.
// A new request is taken only once the previous one is through; no division
// is needed when filter_tau and sample_time are both zero. The result sits in
// an output register, so the next request is accepted while the previous
// result still waits to be taken. Gains, timing and limits are to be written
// through the configuration port only while no request is in flight; the
// block does not enforce this. Reset restores their defaults and clears the
// integrator, the previous error, the filtered derivative and the previous
// measurement.
module pid_controller_antiwindup #(
  parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Request channel.
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [2*pidaw_pkg::FIELD_W-1:0]        s_tdata,    // target, measured
  // Result channel.
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [pidaw_pkg::FIELD_W-1:0]          m_tdata,    // drive
  // Configuration write port.
  input  logic                                   cfg_wen,
  input  logic [pidaw_pkg::ADDR_W-1:0]           cfg_index,
  input  logic [pidaw_pkg::FIELD_W-1:0]          cfg_wdata
);

  localparam int FIELD_W = pidaw_pkg::FIELD_W;
  localparam int GAIN_W  = pidaw_pkg::GAIN_W;
  localparam int OPND_W  = pidaw_pkg::OPND_W;
  localparam int PROD_W  = pidaw_pkg::PROD_W;
  localparam int DEN_W   = pidaw_pkg::DEN_W;
  localparam int SUM_W   = FIELD_W + 2;
  localparam logic signed [FIELD_W-1:0] D_NEG_LIMIT = pidaw_pkg::SAT_MIN[FIELD_W-1:0];

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_KT,
    ST_MUL_A,
    ST_MUL_INC,
    ST_MUL_B,
    ST_SUM,
    ST_CLAMP,
    ST_DIV,
    ST_FINAL
  } state_t;

  // Configuration registers.
  logic [GAIN_W-1:0]         kp;
  logic [GAIN_W-1:0]         ki;
  logic [GAIN_W-1:0]         kd;
  logic [GAIN_W-1:0]         sample_time;
  logic [GAIN_W-1:0]         filter_tau;
  logic signed [FIELD_W-1:0] out_min;
  logic signed [FIELD_W-1:0] out_max;

  // Controller state carried from one request to the next.
  logic signed [FIELD_W-1:0] integral_acc;
  logic signed [FIELD_W-1:0] last_error;
  logic signed [FIELD_W-1:0] deriv_filtered;
  logic signed [FIELD_W-1:0] last_measured;

  // Working registers of the current request.
  state_t                    state;
  logic signed [FIELD_W-1:0] meas_r;
  logic signed [FIELD_W-1:0] e_r;
  logic signed [FIELD_W-1:0] p_r;
  logic signed [FIELD_W-1:0] kt_r;
  logic signed [FIELD_W-1:0] a_r;
  logic signed [FIELD_W-1:0] inc_r;
  logic signed [FIELD_W-1:0] i_r;
  logic signed [FIELD_W-1:0] hi_r;
  logic signed [FIELD_W-1:0] lo_r;
  logic signed [FIELD_W-1:0] n_r;
  logic signed [FIELD_W-1:0] d_r;
  logic [DEN_W-1:0]          den_r;

  // Combinational helpers.
  logic signed [FIELD_W-1:0] in_target;
  logic signed [FIELD_W-1:0] in_measured;
  logic signed [OPND_W-1:0]  err_diff;
  logic signed [OPND_W-1:0]  meas_diff;
  logic signed [OPND_W-1:0]  err_sum;
  logic signed [OPND_W-1:0]  filt_coef;
  logic [DEN_W-1:0]          den;
  logic signed [OPND_W-1:0]  mul_a;
  logic signed [OPND_W-1:0]  mul_b;
  pidaw_pkg::mul_shift_t     mul_shift;
  logic signed [FIELD_W-1:0] mul_res;
  logic signed [OPND_W-1:0]  hi_diff;
  logic signed [OPND_W-1:0]  lo_diff;
  logic signed [SUM_W-1:0]   n_sum;
  logic signed [SUM_W-1:0]   i_sum;
  logic signed [SUM_W-1:0]   y_sum;
  logic signed [FIELD_W-1:0] y_sat;
  logic signed [FIELD_W-1:0] y_out;
  logic [FIELD_W-1:0]        n_mag;
  logic [FIELD_W-1:0]        d_mag;
  logic                      div_start;
  pidaw_pkg::div_stat_t      div_stat;
  logic [FIELD_W-2:0]        div_quot;
  logic                      out_free;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes to unused indexes are dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      kp          <= pidaw_pkg::KP_RST;
      ki          <= pidaw_pkg::KI_RST;
      kd          <= pidaw_pkg::KD_RST;
      sample_time <= pidaw_pkg::SAMPLE_TIME_RST;
      filter_tau  <= pidaw_pkg::FILTER_TAU_RST;
      out_min     <= pidaw_pkg::OUT_MIN_RST;
      out_max     <= pidaw_pkg::OUT_MAX_RST;
    end else if (cfg_wen) begin
      unique case (pidaw_pkg::reg_index_t'(cfg_index))
        pidaw_pkg::REG_KP:          kp          <= cfg_wdata[GAIN_W-1:0];
        pidaw_pkg::REG_KI:          ki          <= cfg_wdata[GAIN_W-1:0];
        pidaw_pkg::REG_KD:          kd          <= cfg_wdata[GAIN_W-1:0];
        pidaw_pkg::REG_SAMPLE_TIME: sample_time <= cfg_wdata[GAIN_W-1:0];
        pidaw_pkg::REG_FILTER_TAU:  filter_tau  <= cfg_wdata[GAIN_W-1:0];
        pidaw_pkg::REG_OUT_MIN:     out_min     <= $signed(cfg_wdata);
        pidaw_pkg::REG_OUT_MAX:     out_max     <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Operand preparation. All differences and sums are kept one bit wider than
  // the fields so that nothing wraps before the multiplier sees it.
  // --------------------------------------------------------------------------
  assign in_target   = $signed(s_tdata[FIELD_W-1:0]);
  assign in_measured = $signed(s_tdata[2*FIELD_W-1:FIELD_W]);
  assign err_diff    = OPND_W'(in_target) - OPND_W'(in_measured);
  assign meas_diff   = OPND_W'(meas_r) - OPND_W'(last_measured);
  assign err_sum     = OPND_W'(e_r) + OPND_W'(last_error);
  // Filter coefficient 2*tau - T can go negative; the denominator cannot.
  assign filt_coef   = $signed({1'b0, filter_tau, 1'b0}) - $signed({2'b0, sample_time});
  assign den         = {1'b0, filter_tau, 1'b0} + {2'b0, sample_time};

  // The shared multiplier takes one product per state; its saturated result
  // is picked up in the following state.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_shift = pidaw_pkg::SHIFT_F;
    unique case (state)
      ST_MUL_P: begin
        mul_a = $signed({2'b0, kp});
        mul_b = OPND_W'(e_r);
      end
      ST_MUL_KT: begin
        mul_a = $signed({2'b0, ki});
        mul_b = $signed({2'b0, sample_time});
      end
      ST_MUL_A: begin
        // Derivative on measurement, with the factor of two folded into the
        // shift.
        mul_a     = $signed({2'b0, kd});
        mul_b     = meas_diff;
        mul_shift = pidaw_pkg::SHIFT_FM1;
      end
      ST_MUL_INC: begin
        // Trapezoidal rule: the halving of (e + last e) is folded into the
        // shift.
        mul_a     = OPND_W'(kt_r);
        mul_b     = err_sum;
        mul_shift = pidaw_pkg::SHIFT_FP1;
      end
      ST_MUL_B: begin
        mul_a = filt_coef;
        mul_b = OPND_W'(deriv_filtered);
      end
      default: ;
    endcase
  end

  pidaw_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .shift  (mul_shift),
    .result (mul_res)
  );

  // --------------------------------------------------------------------------
  // Integrator bounds, sums and output limiting.
  // --------------------------------------------------------------------------
  // The integrator may only use the headroom left between the proportional
  // term and each output limit; with no headroom on a side the bound is zero.
  assign hi_diff = OPND_W'(out_max) - OPND_W'(p_r);
  assign lo_diff = OPND_W'(out_min) - OPND_W'(p_r);
  assign n_sum   = SUM_W'(a_r) + SUM_W'(mul_res);
  assign i_sum   = SUM_W'(integral_acc) + SUM_W'(inc_r);
  assign y_sum   = SUM_W'(p_r) + SUM_W'(i_r) + SUM_W'(d_r);
  assign y_sat   = pidaw_pkg::sat_data(PROD_W'(y_sum));

  // The upper limit is tested first, which settles crossed limits.
  always_comb begin
    if (y_sat > out_max) begin
      y_out = out_max;
    end else if (y_sat < out_min) begin
      y_out = out_min;
    end else begin
      y_out = y_sat;
    end
  end

  // --------------------------------------------------------------------------
  // Derivative division. The divider works on magnitudes; the sign of the
  // numerator is put back afterwards, negated for the derivative term.
  // --------------------------------------------------------------------------
  assign n_mag     = n_r[FIELD_W-1] ? FIELD_W'(-n_r) : FIELD_W'(n_r);
  assign div_start = (state == ST_CLAMP) && (den_r != '0);
  assign d_mag     = {1'b0, div_quot};

  pidaw_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n_mag),
    .divisor  (den_r),
    .stat     (div_stat),
    .quot     (div_quot)
  );

  // --------------------------------------------------------------------------
  // Sequencer with the working registers, the controller state and the
  // output register.
  // --------------------------------------------------------------------------
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      m_tvalid       <= 1'b0;
      integral_acc   <= '0;
      last_error     <= '0;
      deriv_filtered <= '0;
      last_measured  <= '0;
    end else begin
      // A new result replaces a taken one in the same cycle.
      if (state == ST_FINAL && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            meas_r <= in_measured;
            e_r    <= pidaw_pkg::sat_data(PROD_W'(err_diff));
            state  <= ST_MUL_P;
          end
        end
        ST_MUL_P: begin
          state <= ST_MUL_KT;
        end
        ST_MUL_KT: begin
          p_r   <= mul_res;
          state <= ST_MUL_A;
        end
        ST_MUL_A: begin
          kt_r  <= mul_res;
          state <= ST_MUL_INC;
        end
        ST_MUL_INC: begin
          a_r   <= mul_res;
          hi_r  <= (out_max > p_r) ? pidaw_pkg::sat_data(PROD_W'(hi_diff)) : '0;
          lo_r  <= (out_min < p_r) ? pidaw_pkg::sat_data(PROD_W'(lo_diff)) : '0;
          state <= ST_MUL_B;
        end
        ST_MUL_B: begin
          inc_r <= mul_res;
          state <= ST_SUM;
        end
        ST_SUM: begin
          n_r   <= pidaw_pkg::sat_data(PROD_W'(n_sum));
          i_r   <= pidaw_pkg::sat_data(PROD_W'(i_sum));
          den_r <= den;
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          // Anti-windup clamp; the upper bound is tested first, though the bounds never cross.
          if (i_r > hi_r) begin
            i_r <= hi_r;
          end else if (i_r < lo_r) begin
            i_r <= lo_r;
          end
          // With tau and T both zero the derivative term is simply zero.
          if (den_r == '0) begin
            d_r   <= '0;
            state <= ST_FINAL;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            d_r   <= n_r[FIELD_W-1] ? $signed(d_mag) : -$signed(d_mag);
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            m_tdata        <= y_out;
            integral_acc   <= i_r;
            deriv_filtered <= d_r;
            last_error     <= e_r;
            last_measured  <= meas_r;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while the previous one is still in work");

  a_div_tracks_seq: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_stat.busy || div_stat.done)
    else $error("sequencer waits on an idle divider");

  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FINAL))
    else $error("result presented outside the final step");

  a_deriv_symmetric: assert property (@(posedge clk) disable iff (rst)
    deriv_filtered != D_NEG_LIMIT)
    else $error("negated derivative reached the most negative value");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Testbench for the anti-windup PID controller
// Streams setpoint and measurement requests into the controller under several
// gain, timing and limit settings, predicts every drive value in a model of
// its own and compares each returned drive value against the oldest
// prediction.
// ============================================================================
module tb;
  import pidaw_pkg::*;

  // Cycles without any accepted request or result before the run is abandoned.
  // The limit leaves room for the slowest request plus short idle bursts.
  localparam int WATCHDOG_LIMIT = 2000;
  // Index that no register answers to. Writes to it must change nothing.
  localparam logic [ADDR_W-1:0] REG_UNMAPPED = 3'd7;

  localparam logic signed [FIELD_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] ONE   = 32'sd65536;

  // --------------------------------------------------------------------------
  // Drive value predictor and result store.
  // --------------------------------------------------------------------------
  class drive_scoreboard;
    localparam longint CLIP_HI = 64'sd2147483647;
    localparam longint CLIP_LO = -64'sd2147483648;

    // Register copies.
    longint kp, ki, kd, t_s, tau, o_min, o_max;
    // Loop state.
    longint integ_acc, prev_err, d_filt, prev_meas;
    // Drive values still owed by the controller, oldest first.
    logic [FIELD_W-1:0] owed_drive[$];
    int mismatches;
    int results_seen;

    function new();
      kp = KP_RST;
      ki = KI_RST;
      kd = KD_RST;
      t_s = SAMPLE_TIME_RST;
      tau = FILTER_TAU_RST;
      o_min = OUT_MIN_RST;
      o_max = OUT_MAX_RST;
      integ_acc = 0;
      prev_err = 0;
      d_filt = 0;
      prev_meas = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function longint clip(longint x);
      if (x > CLIP_HI) return CLIP_HI;
      if (x < CLIP_LO) return CLIP_LO;
      return x;
    endfunction

    // Gains and times keep their low 31 bits; limits are signed 32-bit values.
    function void write_reg(logic [ADDR_W-1:0] idx, logic [FIELD_W-1:0] val);
      longint u31;
      longint s32;
      u31 = longint'({1'b0, val[GAIN_W-1:0]});
      s32 = longint'(signed'(val));
      case (idx)
        REG_KP:          kp = u31;
        REG_KI:          ki = u31;
        REG_KD:          kd = u31;
        REG_SAMPLE_TIME: t_s = u31;
        REG_FILTER_TAU:  tau = u31;
        REG_OUT_MIN:     o_min = s32;
        REG_OUT_MAX:     o_max = s32;
        default: ;
      endcase
    endfunction

    // One control step. Right shifts of signed values round toward minus
    // infinity; the derivative division truncates toward zero.
    function logic [FIELD_W-1:0] predict_drive(logic signed [FIELD_W-1:0] tg,
                                               logic signed [FIELD_W-1:0] ms);
      longint t, m, e, p, kt, inc, integ, hi, lo, a, b, n, den, d, y;
      t = tg;
      m = ms;
      e = clip(t - m);
      p = clip((kp * e) >>> FRAC_BITS);

      // Trapezoidal integral, then clamped against the headroom left by p.
      kt = clip((ki * t_s) >>> FRAC_BITS);
      inc = clip((kt * (e + prev_err)) >>> (FRAC_BITS + 1));
      integ = clip(integ_acc + inc);
      hi = (o_max > p) ? clip(o_max - p) : 0;
      lo = (o_min < p) ? clip(o_min - p) : 0;
      if (integ > hi) integ = hi;
      else if (integ < lo) integ = lo;

      // Filtered derivative on the measurement.
      a = clip((kd * (m - prev_meas)) >>> (FRAC_BITS - 1));
      b = clip(((2 * tau - t_s) * d_filt) >>> FRAC_BITS);
      n = clip(a + b);
      den = 2 * tau + t_s;
      if (den == 0) d = 0;
      else d = clip(-clip((n <<< FRAC_BITS) / den));

      y = clip(p + integ + d);
      if (y > o_max) y = o_max;
      else if (y < o_min) y = o_min;

      integ_acc = integ;
      d_filt = d;
      prev_err = e;
      prev_meas = m;
      return y[FIELD_W-1:0];
    endfunction

    function void note_request(logic signed [FIELD_W-1:0] tg,
                               logic signed [FIELD_W-1:0] ms);
      owed_drive.push_back(predict_drive(tg, ms));
    endfunction

    function int pending();
      return owed_drive.size();
    endfunction

    task report_mismatch(string what, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
      if (mismatches < 30)
        $display("[%0t] result %0d: %s, got %h expected %h", $time, results_seen, what,
                 got, want);
      mismatches++;
    endtask

    task check_drive(logic [FIELD_W-1:0] got);
      logic [FIELD_W-1:0] want;
      if (owed_drive.size() == 0) begin
        report_mismatch("drive value with no request outstanding", got, 'x);
      end else begin
        want = owed_drive.pop_front();
        if (got !== want) report_mismatch("drive differs", got, want);
      end
      results_seen++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [2*FIELD_W-1:0] s_tdata = '0;   // target, measured
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [FIELD_W-1:0] m_tdata;          // drive
  logic cfg_wen = 1'b0;
  logic [ADDR_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0] cfg_wdata = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pid_controller_antiwindup dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  drive_scoreboard sb = new();

  // When set, both sides idle now and then.
  bit allow_idle = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  // Loop state for the random walk that imitates a plant following its setpoint.
  logic signed [FIELD_W-1:0] walk_target = '0;
  logic signed [FIELD_W-1:0] walk_meas = '0;

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, result checking and the watchdog.
  // All signals are read right at the clock edge, before any update lands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end

    if (!rst && m_tvalid && m_tready) sb.check_drive(m_tdata);

    if (!rst && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no progress for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------
  // Presents one request and returns at the edge that accepts it. The valid
  // stays high on return so that back-to-back requests leave no hole; it is
  // only lowered for an idle burst or by end_requests.
  task automatic send_request(input logic signed [FIELD_W-1:0] tg,
                              input logic signed [FIELD_W-1:0] ms);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ms, tg};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(tg, ms);
  endtask

  // Lowers the valid and waits until every owed drive value has come back,
  // so that the controller is idle before registers change.
  task automatic end_requests();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Register writes leave the write enable high so that consecutive writes
  // run on consecutive edges; end_writes drops it.
  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [FIELD_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic end_writes();
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [FIELD_W-1:0] kp_v, ki_v, kd_v, ts_v, tau_v,
                                input logic [FIELD_W-1:0] min_v, max_v);
    write_reg(REG_KP, kp_v);
    write_reg(REG_KI, ki_v);
    write_reg(REG_KD, kd_v);
    write_reg(REG_SAMPLE_TIME, ts_v);
    write_reg(REG_FILTER_TAU, tau_v);
    write_reg(REG_OUT_MIN, min_v);
    write_reg(REG_OUT_MAX, max_v);
    end_writes();
  endtask

  // Either settings a real loop would use (gains of a few units, sample
  // periods up to a tenth of a second, limits of a few units) or arbitrary
  // words, with the upper bits of the unsigned registers set at random.
  task automatic random_settings(input bit wild);
    logic signed [FIELD_W-1:0] lim_a, lim_b, ts_v;
    if (wild) begin
      lim_a = $urandom;
      lim_b = $urandom;
      ts_v = $urandom;
      if (ts_v[GAIN_W-1:0] == '0) ts_v = 32'd1;
      if (lim_a > lim_b) apply_settings($urandom, $urandom, $urandom, ts_v, $urandom,
                                        lim_b, lim_a);
      else apply_settings($urandom, $urandom, $urandom, ts_v, $urandom, lim_a, lim_b);
    end else begin
      lim_a = $urandom_range(1 << 16, 20 << 16);
      lim_b = -$signed($urandom_range(0, 20 << 16));
      apply_settings($urandom_range(0, 4 << 16), $urandom_range(0, 8 << 16),
                     $urandom_range(0, 1 << 16), $urandom_range(1, 6554),
                     $urandom_range(0, 13107), lim_b, lim_a);
    end
  endtask

  function automatic logic signed [FIELD_W-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      default: return -32'sd1;
    endcase
  endfunction

  // Mostly a plant that moves toward the setpoint with noise, so the
  // integrator and derivative filter see long coherent histories; the rest
  // are arbitrary words and corner values.
  task automatic run_random_phase(input int count, input int span);
    int k;
    int pick;
    int step;
    step = span / 16 + 1;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if ($urandom_range(0, 15) == 0)
          walk_target = int'($urandom_range(0, 2 * span)) - span;
        walk_meas = walk_meas + (walk_target - walk_meas) / 8
                    + (int'($urandom_range(0, 2 * step)) - step);
        send_request(walk_target, walk_meas);
      end else if (pick < 9) begin
        send_request($urandom, $urandom);
      end else begin
        send_request(extreme_value(), extreme_value());
      end
    end
    end_requests();
  endtask

  initial begin
    int ph;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: field extremes and small signs around zero.
    send_request(0, 0);
    send_request(S_MAX, S_MIN);
    send_request(S_MIN, S_MAX);
    send_request(S_MAX, S_MAX);
    send_request(S_MIN, S_MIN);
    send_request(ONE, 0);
    send_request(0, ONE);
    send_request(-32'sd1, 0);
    send_request(0, -32'sd1);
    end_requests();

    // Zero denominator: with tau and T both zero the derivative is dropped.
    apply_settings(ONE, ONE, ONE, 0, 0, -ONE, ONE);
    send_request(ONE, 0);
    send_request(0, ONE);
    send_request(S_MIN, S_MAX);
    end_requests();

    // Crossed limits; the integrator bounds still do not cross. A write to an
    // unmapped index must leave every register alone.
    apply_settings(ONE, ONE, ONE, 655, 1311, 2 * ONE, -2 * ONE);
    write_reg(REG_UNMAPPED, 32'h5A5A_A5A5);
    end_writes();
    send_request(S_MAX, S_MIN);
    send_request(S_MIN, S_MAX);
    send_request(0, 0);
    end_requests();

    // Every register at its largest value, limits spanning the full range.
    apply_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, S_MIN, S_MAX);
    send_request(S_MAX, S_MIN);
    send_request(S_MIN, S_MAX);
    send_request(32'sd1, 0);
    send_request(0, 0);
    end_requests();

    // Zero gains and a pinned output.
    apply_settings(0, 0, 0, 1, 0, 0, 0);
    send_request(S_MAX, S_MIN);
    send_request(32'sd123, -32'sd5);
    end_requests();

    // Random part: eight settings, two of them arbitrary words. The last
    // phase runs with both sides always ready.
    for (ph = 0; ph < 8; ph++) begin
      allow_idle = (ph < 7) && ($urandom_range(0, 3) != 0);
      random_settings(ph == 2 || ph == 5);
      run_random_phase(210, 1 << $urandom_range(12, 24));
    end
    allow_idle = 1'b0;

    repeat (FRAC_BITS + 42) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
